>>> hw/rtl/euclidean_mst_kruskal_core_assert.svh
// Assertion macros for the minimum spanning forest core
`ifndef EUCLIDEAN_MST_KRUSKAL_CORE_ASSERT_SVH
`define EUCLIDEAN_MST_KRUSKAL_CORE_ASSERT_SVH

// same-cycle implication under the core clock and reset
`define EMK_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under the core clock and reset
`define EMK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/emk_pkg.sv
// Shared types and constants of the minimum spanning forest core
package emk_pkg;

    localparam int OP_W   = 2;
    localparam int NODE_W = 7;
    localparam int CRD_W  = 16;
    localparam int CNT_W  = 6;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_LINK  = 2'd1;
    localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;

    typedef enum logic [2:0] {
        RS_A = 3'd0,
        RS_B = 3'd1,
        RS_I = 3'd2,
        RS_J = 3'd3,
        RS_K = 3'd4
    } t_rsel;

    typedef struct packed {
        logic  wr_point;
        logic  cap_link;
        t_rsel rd_sel;
        logic  cap_la;
        logic  cap_lb;
        logic  sweep_step;
        logic  solve_go;
        logic  scan_init;
        logic  cap_i;
        logic  diff;
        logic  sqr;
        logic  cmp;
        logic  take_best;
        logic  out_cnt;
        logic  acc_rd;
        logic  out_pair;
        logic  clr_sets;
    } t_cmd;

    typedef struct packed {
        logic ab_ok;
        logic n_small;
        logic last_pair;
        logic found;
        logic sweep_done;
        logic out_taken;
        logic emit_done;
    } t_sts;

endpackage

>>> hw/rtl/emk_if.sv
// Handshake channels of the minimum spanning forest core
interface emk_in_if;
    import emk_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [CRD_W-1:0]  x_coord;
    logic signed [CRD_W-1:0]  y_coord;
    modport source (output valid, opcode, node_a, node_b, x_coord, y_coord, input ready);
    modport sink (input valid, opcode, node_a, node_b, x_coord, y_coord, output ready);
endinterface

interface emk_out_if;
    import emk_pkg::*;
    logic              valid;
    logic              ready;
    logic              is_count;
    logic [CNT_W-1:0]  edge_count;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
    logic              last;
    modport source (output valid, is_count, edge_count, edge_from, edge_to, last, input ready);
    modport sink (input valid, is_count, edge_count, edge_from, edge_to, last, output ready);
endinterface

interface emk_cfg_if;
    import emk_pkg::*;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/emk_ctrl.sv
// Sequencer of the minimum spanning forest core
module emk_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [emk_pkg::OP_W-1:0] i_opcode,
    output logic                     o_in_ready,
    input  emk_pkg::t_sts            i_sts,
    output emk_pkg::t_cmd            o_cmd
);
    import emk_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_LRA   = 15'h0002,
        S_LRB   = 15'h0004,
        S_LCAP  = 15'h0008,
        S_SWEEP = 15'h0010,
        S_RDI   = 15'h0020,
        S_RDJ   = 15'h0040,
        S_DIFF  = 15'h0080,
        S_SQR   = 15'h0100,
        S_CMP   = 15'h0200,
        S_SEND  = 15'h0400,
        S_OCNT  = 15'h0800,
        S_OWAIT = 15'h1000,
        S_ORD   = 15'h2000,
        S_OLD   = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   r_solving, n_solving;

    always_comb begin
        n_state    = r_state;
        n_solving  = r_solving;
        o_cmd      = '0;
        o_cmd.rd_sel = RS_I;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_LOAD: o_cmd.wr_point = 1'b1;
                        OP_LINK: begin
                            if (i_sts.ab_ok) begin
                                o_cmd.cap_link = 1'b1;
                                n_solving      = 1'b0;
                                n_state        = S_LRA;
                            end
                        end
                        OP_SOLVE: begin
                            o_cmd.solve_go  = 1'b1;
                            o_cmd.scan_init = 1'b1;
                            n_solving       = 1'b1;
                            n_state         = S_RDI;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LRA: begin
                o_cmd.rd_sel = RS_A;
                n_state      = S_LRB;
            end
            S_LRB: begin
                o_cmd.rd_sel = RS_B;
                o_cmd.cap_la = 1'b1;
                n_state      = S_LCAP;
            end
            S_LCAP: begin
                o_cmd.cap_lb = 1'b1;
                n_state      = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.rd_sel     = RS_K;
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    if (r_solving) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_RDI;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RDI: begin
                if (i_sts.n_small) begin
                    n_state = S_SEND;
                end else begin
                    o_cmd.rd_sel = RS_I;
                    n_state      = S_RDJ;
                end
            end
            S_RDJ: begin
                o_cmd.rd_sel = RS_J;
                o_cmd.cap_i  = 1'b1;
                n_state      = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQR;
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.last_pair ? S_SEND : S_RDI;
            end
            S_SEND: begin
                if (i_sts.found) begin
                    o_cmd.take_best = 1'b1;
                    n_state         = S_SWEEP;
                end else begin
                    n_state = S_OCNT;
                end
            end
            S_OCNT: begin
                o_cmd.out_cnt = 1'b1;
                n_state       = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.emit_done) begin
                        o_cmd.clr_sets = 1'b1;
                        n_solving      = 1'b0;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            S_ORD: begin
                o_cmd.acc_rd = 1'b1;
                n_state      = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_pair = 1'b1;
                n_state        = S_OWAIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_solving <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_solving <= n_solving;
        end
    end

endmodule

>>> hw/rtl/emk_dp.sv
// Datapath of the minimum spanning forest core: stores, distance unit, output register
module emk_dp #(
    parameter int MAX_NODES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  emk_pkg::t_cmd                     i_cmd,
    output emk_pkg::t_sts                     o_sts,
    input  logic [emk_pkg::NODE_W-1:0]        i_node_a,
    input  logic [emk_pkg::NODE_W-1:0]        i_node_b,
    input  logic signed [emk_pkg::CRD_W-1:0]  i_x_coord,
    input  logic signed [emk_pkg::CRD_W-1:0]  i_y_coord,
    input  logic                              i_cfg_valid,
    input  logic [emk_pkg::NODE_W-1:0]        i_cfg_data,
    output logic                              o_cfg_ready,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_is_count,
    output logic [emk_pkg::CNT_W-1:0]         o_edge_count,
    output logic [emk_pkg::NODE_W-1:0]        o_edge_from,
    output logic [emk_pkg::NODE_W-1:0]        o_edge_to,
    output logic                              o_last
);
    import emk_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int K_W   = IDX_W + 1;
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int DX_W  = COORD_BITS + 1;
    localparam int PR_W  = 2 * COORD_BITS + 2;
    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int WT_W  = 2 * COORD_BITS + 2;

    logic [PT_W-1:0]          point_mem [MAX_NODES];
    logic [IDX_W-1:0]         lbl_mem   [MAX_NODES];
    logic [2*IDX_W-1:0]       acc_mem   [MAX_NODES];
    logic [MAX_NODES-1:0]     r_lvalid;

    logic [NODE_W-1:0]        r_ncfg;
    logic [NODE_W-1:0]        w_n;
    logic [IDX_W-1:0]         r_pa, r_pb;
    logic [IDX_W-1:0]         w_addr;
    logic [PT_W-1:0]          r_pq;
    logic [IDX_W-1:0]         r_lq, r_raq;
    logic                     r_lvq;
    logic [IDX_W-1:0]         w_lbl;
    logic [IDX_W-1:0]         r_la, r_lb;
    logic [K_W-1:0]           r_k;
    logic [IDX_W-1:0]         r_kw;
    logic                     r_kv;
    logic [IDX_W-1:0]         r_i, r_j;
    logic signed [COORD_BITS-1:0] r_xi, r_yi, w_xj, w_yj;
    logic [IDX_W-1:0]         r_li, r_lj;
    logic signed [DX_W-1:0]   r_dx, r_dy;
    logic                     r_dif;
    logic signed [PR_W-1:0]   w_px, w_py;
    logic [SQ_W-1:0]          r_sx, r_sy;
    logic [WT_W-1:0]          w_sum;
    logic                     r_found;
    logic [WT_W-1:0]          r_bw;
    logic [IDX_W-1:0]         r_bi, r_bj, r_bli, r_blj;
    logic [IDX_W-1:0]         r_count, r_e;
    logic [2*IDX_W-1:0]       r_aq;
    logic                     w_a_ok, w_b_ok, w_lbl_wr;

    assign o_cfg_ready = 1'b1;
    assign w_n    = (r_ncfg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_ncfg;
    assign w_a_ok = (i_node_a != '0) && (i_node_a <= NODE_W'(MAX_NODES));
    assign w_b_ok = (i_node_b != '0) && (i_node_b <= NODE_W'(MAX_NODES));
    assign w_lbl  = r_lvq ? r_lq : r_raq;
    assign w_xj   = r_pq[PT_W-1:COORD_BITS];
    assign w_yj   = r_pq[COORD_BITS-1:0];
    assign w_px   = r_dx * r_dx;
    assign w_py   = r_dy * r_dy;
    assign w_sum  = WT_W'(r_sx) + WT_W'(r_sy);
    assign w_lbl_wr = i_cmd.sweep_step && r_kv && (w_lbl == r_la);

    assign o_sts.ab_ok      = w_a_ok && w_b_ok;
    assign o_sts.n_small    = (w_n < NODE_W'(2));
    assign o_sts.last_pair  = (NODE_W'(r_i) + NODE_W'(2) == w_n) &&
                              (NODE_W'(r_j) + NODE_W'(1) == w_n);
    assign o_sts.found      = r_found;
    assign o_sts.sweep_done = (r_k == K_W'(MAX_NODES));
    assign o_sts.out_taken  = o_out_valid && i_out_ready;
    assign o_sts.emit_done  = (r_e == r_count);

    always_comb begin
        case (i_cmd.rd_sel)
            RS_A:    w_addr = r_pa;
            RS_B:    w_addr = r_pb;
            RS_I:    w_addr = r_i;
            RS_J:    w_addr = r_j;
            RS_K:    w_addr = r_k[IDX_W-1:0];
            default: w_addr = r_i;
        endcase
    end

    // point and label stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point && w_a_ok) begin
            point_mem[IDX_W'(i_node_a - NODE_W'(1))] <=
                {COORD_BITS'(i_x_coord), COORD_BITS'(i_y_coord)};
        end
        if (w_lbl_wr) begin
            lbl_mem[r_kw] <= r_lb;
        end
        r_pq  <= point_mem[w_addr];
        r_lq  <= lbl_mem[w_addr];
        r_lvq <= r_lvalid[w_addr];
        r_raq <= w_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_best) begin
            acc_mem[r_count] <= {r_bi, r_bj};
        end
        if (i_cmd.acc_rd) begin
            r_aq <= acc_mem[r_e];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncfg      <= NODE_W'(1);
            r_lvalid    <= '0;
            r_k         <= '0;
            r_kv        <= 1'b0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_e         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ncfg <= i_cfg_data;
            end
            if (i_cmd.clr_sets) begin
                r_lvalid <= '0;
            end else if (w_lbl_wr) begin
                r_lvalid[r_kw] <= 1'b1;
            end
            if (i_cmd.cap_lb || i_cmd.take_best) begin
                r_k  <= '0;
                r_kv <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                r_kv <= (r_k < K_W'(MAX_NODES));
                if (r_k < K_W'(MAX_NODES)) begin
                    r_k <= r_k + K_W'(1);
                end
            end
            if (i_cmd.solve_go) begin
                r_count <= '0;
            end else if (i_cmd.take_best) begin
                r_count <= r_count + IDX_W'(1);
            end
            if (i_cmd.scan_init) begin
                r_i     <= '0;
                r_j     <= IDX_W'(1);
                r_found <= 1'b0;
            end else if (i_cmd.cmp) begin
                if (r_dif && (!r_found || (w_sum < r_bw))) begin
                    r_found <= 1'b1;
                end
                if (NODE_W'(r_j) + NODE_W'(1) == w_n) begin
                    r_i <= r_i + IDX_W'(1);
                    r_j <= r_i + IDX_W'(2);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
            if (i_cmd.out_cnt) begin
                r_e <= '0;
            end else if (i_cmd.out_pair) begin
                r_e <= r_e + IDX_W'(1);
            end
            if (i_cmd.out_cnt || i_cmd.out_pair) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kw <= r_k[IDX_W-1:0];
        if (i_cmd.cap_link) begin
            r_pa <= IDX_W'(i_node_a - NODE_W'(1));
            r_pb <= IDX_W'(i_node_b - NODE_W'(1));
        end
        if (i_cmd.cap_la) begin
            r_la <= w_lbl;
        end
        if (i_cmd.cap_lb) begin
            r_lb <= w_lbl;
        end
        if (i_cmd.take_best) begin
            r_la <= r_bli;
            r_lb <= r_blj;
        end
        if (i_cmd.cap_i) begin
            r_xi <= w_xj;
            r_yi <= w_yj;
            r_li <= w_lbl;
        end
        if (i_cmd.diff) begin
            r_dx  <= DX_W'(r_xi) - DX_W'(w_xj);
            r_dy  <= DX_W'(r_yi) - DX_W'(w_yj);
            r_lj  <= w_lbl;
            r_dif <= (r_li != w_lbl);
        end
        if (i_cmd.sqr) begin
            r_sx <= w_px[SQ_W-1:0];
            r_sy <= w_py[SQ_W-1:0];
        end
        if (i_cmd.cmp && r_dif && (!r_found || (w_sum < r_bw))) begin
            r_bw  <= w_sum;
            r_bi  <= r_i;
            r_bj  <= r_j;
            r_bli <= r_li;
            r_blj <= r_lj;
        end
        if (i_cmd.out_cnt) begin
            o_is_count   <= 1'b1;
            o_edge_count <= CNT_W'(r_count);
            o_edge_from  <= '0;
            o_edge_to    <= '0;
            o_last       <= (r_count == '0);
        end else if (i_cmd.out_pair) begin
            o_is_count   <= 1'b0;
            o_edge_count <= '0;
            o_edge_from  <= NODE_W'(r_aq[2*IDX_W-1:IDX_W]) + NODE_W'(1);
            o_edge_to    <= NODE_W'(r_aq[IDX_W-1:0]) + NODE_W'(1);
            o_last       <= (K_W'(r_e) + K_W'(1) == K_W'(r_count));
        end
    end

endmodule

>>> hw/rtl/euclidean_mst_kruskal_core.sv
// Minimum spanning forest core. A point item, a link with an end out of range and an
// unknown opcode are each handled as they are accepted. A link item is accepted, then
// does two label reads and the label capture, then a relabel sweep over the whole
// label store. A solve is accepted, then scans all n(n-1)/2 pairs once per accepted
// pair plus one final scan, each pair in the steps two point reads, difference, squares
// and compare, and each scan ends in a decision step (a scan with n below 2 is one read
// and the decision step); each accepted pair adds a relabel sweep. The count item is
// loaded and held until taken; each pair item is read from the edge store, loaded and
// held until taken. The point and label stores each have one read address, so their
// reads are made one at a time. Input is stalled for the whole link and solve.
module euclidean_mst_kruskal_core #(
    parameter int MAX_NODES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    emk_in_if.sink        i_in,
    emk_cfg_if.sink       i_cfg,
    emk_out_if.source     o_res
);
    import emk_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    emk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    emk_dp #(
        .MAX_NODES  (MAX_NODES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_node_a     (i_in.node_a),
        .i_node_b     (i_in.node_b),
        .i_x_coord    (i_in.x_coord),
        .i_y_coord    (i_in.y_coord),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_cfg_ready  (i_cfg.ready),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_is_count   (o_res.is_count),
        .o_edge_count (o_res.edge_count),
        .o_edge_from  (o_res.edge_from),
        .o_edge_to    (o_res.edge_to),
        .o_last       (o_res.last)
    );

`include "euclidean_mst_kruskal_core_assert.svh"

    `EMK_ASSERT_IMPLY(a_idle_no_result, i_in.ready, !o_res.valid, "item taken with result pending")
    `EMK_ASSERT_IMPLY(a_load_free, w_cmd.out_cnt || w_cmd.out_pair, !o_res.valid, "result overrun")
    `EMK_ASSERT_IMPLY(a_take_found, w_cmd.take_best, w_sts.found, "merge without candidate")
    `EMK_ASSERT_NEXT(a_clr_idle, w_cmd.clr_sets, i_in.ready, "not idle after solve")

endmodule
